[hdl/pssc_pkg.sv]
// ----------------------------------------------------------------------------
// pssc_pkg
// shared types and constants of the two-point sensor scaler
// ----------------------------------------------------------------------------
`default_nettype none

package pssc_pkg;

  // fixed field widths
  localparam int unsigned CmdW   = 2;
  localparam int unsigned ChanW  = 4;
  localparam int unsigned ValueW = 16;

  // command codes carried in tuser
  localparam logic [CmdW-1:0] CmdConvert   = 2'd0;
  localparam logic [CmdW-1:0] CmdStoreLow  = 2'd1;
  localparam logic [CmdW-1:0] CmdStoreHigh = 2'd2;

  // configuration register map
  localparam int unsigned    CfgIdxW    = 1;
  localparam int unsigned    CfgDataW   = 16;
  localparam logic [CfgIdxW-1:0] RegOutLow  = 1'd0;
  localparam logic [CfgIdxW-1:0] RegOutHigh = 1'd1;

  localparam logic [CfgDataW-1:0] OutLowReset  = 16'd0;
  localparam logic [CfgDataW-1:0] OutHighReset = 16'd1023;

  // control flags of a queued conversion job
  typedef struct packed {
    logic bypass;      // result is out_low, skip the arithmetic
    logic calibrated;  // both done flags set at accept time
  } job_ctrl_t;

endpackage

`default_nettype wire

[hdl/pssc_front.sv]
// ----------------------------------------------------------------------------
// pssc_front
// accepts stream items, keeps calibration tables, prepares conversion jobs
// ----------------------------------------------------------------------------
`default_nettype none

module pssc_front #(
  parameter int CHANNELS    = 16,
  parameter int SAMPLE_BITS = 10
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [pssc_pkg::CmdW-1:0]     cmd_i,
  input  wire logic [pssc_pkg::ChanW-1:0]    chan_i,
  input  wire logic [SAMPLE_BITS-1:0]        sample_i,
  input  wire logic                          last_i,
  input  wire logic                          full_i,
  output logic                               push_o,
  output pssc_pkg::job_ctrl_t                job_ctrl_o,
  output logic [SAMPLE_BITS-1:0]             job_diff_o,
  output logic [SAMPLE_BITS-1:0]             job_span_o
);

  // only channels reachable through the channel field get storage
  localparam int Reach = 1 << pssc_pkg::ChanW;
  localparam int Depth = (CHANNELS < Reach) ? CHANNELS : Reach;
  localparam int IdxW  = (Depth > 1) ? $clog2(Depth) : 1;

  logic [SAMPLE_BITS-1:0] low_tab_q  [Depth];
  logic [SAMPLE_BITS-1:0] high_tab_q [Depth];
  logic                   low_done_q, high_done_q;

  logic                   accept, in_range;
  logic [IdxW-1:0]        idx;
  logic [SAMPLE_BITS-1:0] lo, hi, clamp_hi, clamp;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign in_range   = 32'(chan_i) < 32'(CHANNELS);
  assign idx        = chan_i[IdxW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_done_q  <= 1'b0;
      high_done_q <= 1'b0;
      for (int i = 0; i < Depth; i++) begin
        low_tab_q[i]  <= '0;
        high_tab_q[i] <= '0;
      end
    end else if (accept) begin
      if (cmd_i == pssc_pkg::CmdStoreLow) begin
        if (in_range) low_tab_q[idx] <= sample_i;
        if (last_i)   low_done_q     <= 1'b1;
      end else if (cmd_i == pssc_pkg::CmdStoreHigh) begin
        if (in_range) high_tab_q[idx] <= sample_i;
        if (last_i)   high_done_q     <= 1'b1;
      end
    end
  end

  // table lookup and clamp into [lo, hi]
  always_comb begin
    lo       = in_range ? low_tab_q[idx]  : '0;
    hi       = in_range ? high_tab_q[idx] : '0;
    clamp_hi = (sample_i > hi) ? hi : sample_i;
    clamp    = (clamp_hi < lo) ? lo : clamp_hi;
  end

  assign push_o                = accept && (cmd_i == pssc_pkg::CmdConvert);
  assign job_ctrl_o.calibrated = low_done_q && high_done_q;
  assign job_ctrl_o.bypass     = !(low_done_q && high_done_q) || !in_range || (hi <= lo);
  assign job_diff_o            = clamp - lo;
  assign job_span_o            = hi - lo;

endmodule

`default_nettype wire

[hdl/pssc_queue.sv]
// ----------------------------------------------------------------------------
// pssc_queue
// two-entry job queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module pssc_queue #(
  parameter int WIDTH = 22
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output logic [WIDTH-1:0]      data_o
);

  localparam int Depth = 2;
  localparam int PtrW  = $clog2(Depth);

  logic [WIDTH-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [PtrW:0]    cnt_q;

  assign full_o  = cnt_q == (PtrW + 1)'(Depth);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

`default_nettype wire

[hdl/pssc_back.sv]
// ----------------------------------------------------------------------------
// pssc_back
// scales one job: multiply, 16-step restoring divide, floor fixup, output
// ----------------------------------------------------------------------------
`default_nettype none

module pssc_back #(
  parameter int SAMPLE_BITS = 10
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            empty_i,
  output logic                                 pop_o,
  input  wire pssc_pkg::job_ctrl_t             job_ctrl_i,
  input  wire logic [SAMPLE_BITS-1:0]          job_diff_i,
  input  wire logic [SAMPLE_BITS-1:0]          job_span_i,
  input  wire logic [pssc_pkg::CfgDataW-1:0]   out_low_i,
  input  wire logic [pssc_pkg::CfgDataW-1:0]   out_high_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [pssc_pkg::ValueW-1:0]          out_value_o,
  output logic                                 out_cal_o
);

  localparam int VW    = pssc_pkg::ValueW;
  localparam int ProdW = SAMPLE_BITS + VW;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StMul  = 2'd1;
  localparam logic [1:0] StDiv  = 2'd2;
  localparam logic [1:0] StFin  = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [SAMPLE_BITS-1:0] diff_q, span_q, rem_q, rem_d;
  logic [VW-1:0]          quo_q, quo_d;
  logic [$clog2(VW)-1:0]  step_q, step_d;
  logic                   neg_q, neg_d, cal_q, cal_d;
  logic                   load_job, load_out;

  logic                   neg;
  logic [VW-1:0]          mag;
  logic [ProdW-1:0]       prod;
  logic [SAMPLE_BITS:0]   trial;
  logic                   fit;
  logic [VW-1:0]          result;

  logic                   ovalid_q;
  logic [VW-1:0]          ovalue_q;
  logic                   ocal_q;

  // |out_high - out_low| and its sign
  assign neg  = out_high_i < out_low_i;
  assign mag  = neg ? (out_low_i - out_high_i) : (out_high_i - out_low_i);
  assign prod = ProdW'(diff_q) * ProdW'(mag);

  // quotient fits in VW bits, so the top part of the product starts below span
  assign trial = {rem_q, quo_q[VW-1]};
  assign fit   = trial >= {1'b0, span_q};

  // floor: round toward minus infinity on a negative slope
  assign result = neg_q ? (out_low_i - quo_q - VW'(rem_q != '0)) : (out_low_i + quo_q);

  assign load_job = (state_q == StIdle) && !empty_i;
  assign load_out = (state_q == StFin) && (!ovalid_q || out_ready_i);
  assign pop_o    = load_job;

  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    step_d  = step_q;
    neg_d   = neg_q;
    cal_d   = cal_q;
    case (state_q)
      StIdle: begin
        if (!empty_i) begin
          cal_d = job_ctrl_i.calibrated;
          rem_d = '0;
          quo_d = '0;
          neg_d = 1'b0;
          state_d = job_ctrl_i.bypass ? StFin : StMul;
        end
      end
      StMul: begin
        rem_d   = prod[ProdW-1:VW];
        quo_d   = prod[VW-1:0];
        neg_d   = neg;
        step_d  = '0;
        state_d = StDiv;
      end
      StDiv: begin
        rem_d  = fit ? SAMPLE_BITS'(trial - {1'b0, span_q}) : trial[SAMPLE_BITS-1:0];
        quo_d  = {quo_q[VW-2:0], fit};
        step_d = step_q + 1'b1;
        if (step_q == '1) state_d = StFin;
      end
      StFin: begin
        if (!ovalid_q || out_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out)         ovalid_q <= 1'b1;
      else if (out_ready_i) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    step_q <= step_d;
    neg_q  <= neg_d;
    cal_q  <= cal_d;
    if (load_job) begin
      diff_q <= job_diff_i;
      span_q <= job_span_i;
    end
    if (load_out) begin
      ovalue_q <= result;
      ocal_q   <= cal_q;
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_value_o = ovalue_q;
  assign out_cal_o   = ocal_q;

endmodule

`default_nettype wire

[hdl/per_channel_two_point_sensor_scaler.sv]
// ----------------------------------------------------------------------------
// per_channel_two_point_sensor_scaler
// per-channel two-point linear calibration with clamp
// ----------------------------------------------------------------------------
// Keeps a low and a high calibration point for each multiplexed sensor
// channel (tables cleared at reset). An input transaction with tuser = store
// low / store high writes tdata's sample as that channel's point; tlast on a
// store sets that table's done flag for good. A convert transaction clamps
// the sample to the channel's [low, high] and returns
//   value = out_low + floor((s - low) * (out_high - out_low) / (high - low))
// modulo 2^16, or out_low when not calibrated, the channel is out of range
// or high <= low. tuser of the result carries the calibrated flag. Stores
// give no result. A convert goes from acceptance through the job queue, the
// multiply, 16 divider iterations and a rounding and output step into the
// result register; the back end takes a new job only once the last has
// reached the output register. A convert that resolves to out_low skips
// the multiply and divide. A two-entry job queue and the output register
// let the front keep accepting, until the queue is full, while the back end
// works and a result waits. The user must write out_low / out_high through
// the cfg port while no conversion is in flight; the block does not check it.
// ----------------------------------------------------------------------------
`default_nettype none

module per_channel_two_point_sensor_scaler #(
  parameter int CHANNELS    = 16,
  parameter int SAMPLE_BITS = 10,
  localparam int InDataW    = ((pssc_pkg::ChanW + SAMPLE_BITS + 7) / 8) * 8
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration write port
  input  wire logic                              cfg_we_i,
  input  wire logic [pssc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [pssc_pkg::CfgDataW-1:0]     cfg_wdata_i,
  // input stream
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [InDataW-1:0]                s_axis_tdata,  // channel, sample, zero pad
  input  wire logic [pssc_pkg::CmdW-1:0]         s_axis_tuser,  // cmd
  input  wire logic                              s_axis_tlast,  // last store of a pass
  // result stream
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [pssc_pkg::ValueW-1:0]            m_axis_tdata,  // value
  output logic                                   m_axis_tuser   // calibrated
);

  localparam int JobW = 2 + 2 * SAMPLE_BITS;

  // output range registers
  logic [pssc_pkg::CfgDataW-1:0] out_low_q, out_high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_low_q  <= pssc_pkg::OutLowReset;
      out_high_q <= pssc_pkg::OutHighReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pssc_pkg::RegOutLow:  out_low_q  <= cfg_wdata_i;
        pssc_pkg::RegOutHigh: out_high_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // front to queue
  logic                   push, full;
  pssc_pkg::job_ctrl_t    f_ctrl;
  logic [SAMPLE_BITS-1:0] f_diff, f_span;

  // queue to back
  logic                   pop, empty;
  logic [JobW-1:0]        q_data;
  pssc_pkg::job_ctrl_t    b_ctrl;
  logic [SAMPLE_BITS-1:0] b_diff, b_span;

  // item classification, table updates, clamp
  pssc_front #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .cmd_i      (s_axis_tuser),
    .chan_i     (s_axis_tdata[pssc_pkg::ChanW-1:0]),
    .sample_i   (s_axis_tdata[pssc_pkg::ChanW +: SAMPLE_BITS]),
    .last_i     (s_axis_tlast),
    .full_i     (full),
    .push_o     (push),
    .job_ctrl_o (f_ctrl),
    .job_diff_o (f_diff),
    .job_span_o (f_span)
  );

  // job decoupling between front and back
  pssc_queue #(
    .WIDTH (JobW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({f_ctrl, f_diff, f_span}),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (q_data)
  );

  assign {b_ctrl, b_diff, b_span} = q_data;

  // scaling arithmetic and result register
  pssc_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .pop_o       (pop),
    .job_ctrl_i  (b_ctrl),
    .job_diff_i  (b_diff),
    .job_span_i  (b_span),
    .out_low_i   (out_low_q),
    .out_high_i  (out_high_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_value_o (m_axis_tdata),
    .out_cal_o   (m_axis_tuser)
  );

endmodule

`default_nettype wire
